>>> sv/irs_pkg.sv
// Shared types, codes and arithmetic helpers for the image rescale sampler.
// No dependencies; imported by image_rescale_sampler.
package irs_pkg;

  // Field widths fixed by the stream and register formats
  localparam int COORD_W = 10;
  localparam int CHAN_W  = 8;
  localparam int NCHAN   = 3;
  localparam int DIM_W   = 9;
  localparam int SCALE_W = 18;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 18;
  // Scaled coordinate: column times inverse scale
  localparam int POS_W   = COORD_W + SCALE_W;
  // Effective image size, wide enough for the largest store dimension
  localparam int SIZE_W  = 13;
  // Horizontal blend partial and full blend sum
  localparam int HSUM_W  = FRAC_W + CHAN_W;
  localparam int VSUM_W  = 2 * FRAC_W + CHAN_W + 1;

  typedef enum logic [1:0] {
    CFG_SRC_WIDTH   = 2'd0,
    CFG_SRC_HEIGHT  = 2'd1,
    CFG_INV_SCALE   = 2'd2,
    CFG_SAMPLE_MODE = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  typedef enum logic {
    MODE_NEAREST  = 1'b0,
    MODE_BILINEAR = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_READ,
    ST_BLEND
  } state_e;

  // Channel 0 red, 1 green, 2 blue
  typedef logic [NCHAN-1:0][CHAN_W-1:0] pixel_t;
  typedef logic [NCHAN-1:0][HSUM_W-1:0] hsum_t;

  // (1-a)*c0 + a*c1 with a in 16 fraction bits; result below 2^24
  function automatic logic [HSUM_W-1:0] hblend(input logic [CHAN_W-1:0] c0,
                                               input logic [CHAN_W-1:0] c1,
                                               input logic [FRAC_W-1:0] a);
    logic [FRAC_W:0]   na;
    logic [HSUM_W:0]   s;
    na = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, a};
    s  = (HSUM_W+1)'(na) * (HSUM_W+1)'(c0) + (HSUM_W+1)'(a) * (HSUM_W+1)'(c1);
    return s[HSUM_W-1:0];
  endfunction

  // (1-b)*t0 + b*t1, rounded by a half step and scaled back to 8 bits
  function automatic logic [CHAN_W-1:0] vblend(input logic [HSUM_W-1:0] t0,
                                               input logic [HSUM_W-1:0] t1,
                                               input logic [FRAC_W-1:0] b);
    logic [FRAC_W:0]   nb;
    logic [VSUM_W-1:0] s;
    nb = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, b};
    s  = VSUM_W'(nb) * VSUM_W'(t0) + VSUM_W'(b) * VSUM_W'(t1)
       + VSUM_W'(64'h8000_0000);
    return s[2*FRAC_W +: CHAN_W];
  endfunction

endpackage

>>> sv/image_rescale_sampler.sv
// Image rescale sampler: pixel store plus nearest / bilinear resampling.
// Write word: stored while idle. Sample word: multiply, index, four neighbor reads, then
// blend into the result register, which waits while the previous result is still held.
// One word at a time; a new word is accepted while a result waits downstream.
// rst_ni clears control and configuration (width 256, height 256, scale 1.0,
// bilinear); the pixel store is not cleared and has no clearing pass.
module image_rescale_sampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  irs_pkg::cfg_idx_e      cfg_index_i,
  input  logic [irs_pkg::CFG_W-1:0] cfg_data_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [47:0]            s_axis_tdata,  // column, row, red_in, green_in, blue_in, pad
  input  logic [0:0]             s_axis_tuser,  // action
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [23:0]            m_axis_tdata   // red_out, green_out, blue_out
);
  import irs_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = AW + COORD_W + 1;
  localparam int PIX_W = NCHAN * CHAN_W;

  // configuration registers
  logic [DIM_W-1:0]   src_w_q, src_h_q;
  logic [SCALE_W-1:0] scale_q;
  mode_e              mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DIM_W'(256);
      src_h_q <= DIM_W'(256);
      scale_q <= SCALE_W'(65536);
      mode_q  <= MODE_BILINEAR;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SRC_WIDTH:   src_w_q <= cfg_data_i[DIM_W-1:0];
        CFG_SRC_HEIGHT:  src_h_q <= cfg_data_i[DIM_W-1:0];
        CFG_INV_SCALE:   scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_SAMPLE_MODE: mode_q  <= mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // input word fields
  action_e             in_action;
  logic [COORD_W-1:0]  in_col, in_row;
  pixel_t              in_pix;
  logic                in_fire;

  assign in_action = action_e'(s_axis_tuser[0]);
  assign in_col    = s_axis_tdata[9:0];
  assign in_row    = s_axis_tdata[19:10];
  assign in_pix[0] = s_axis_tdata[27:20];
  assign in_pix[1] = s_axis_tdata[35:28];
  assign in_pix[2] = s_axis_tdata[43:36];
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // effective image size, clamped to 1..MAX
  logic [SIZE_W-1:0] w_eff, h_eff, w_last, h_last;

  always_comb begin
    if (src_w_q == '0) begin
      w_eff = SIZE_W'(1);
    end else if (SIZE_W'(src_w_q) > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = SIZE_W'(src_w_q);
    end
    if (src_h_q == '0) begin
      h_eff = SIZE_W'(1);
    end else if (SIZE_W'(src_h_q) > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = SIZE_W'(src_h_q);
    end
    w_last = w_eff - SIZE_W'(1);
    h_last = h_eff - SIZE_W'(1);
  end

  // control state
  state_e        state_q, state_d;
  logic [2:0]    cnt_q, cnt_d;
  logic          out_free;
  logic          blend_load;

  // datapath registers
  logic [COORD_W-1:0] col_q, row_q;
  logic [POS_W-1:0]   sx_q, sy_q;
  logic [XW-1:0]      x0_q, x1_q;
  logic [YW-1:0]      y0_q, y1_q;
  logic [FRAC_W-1:0]  fa_q, fb_q;
  pixel_t             pix_q;
  hsum_t              t0_q, t1_q;

  // result register
  logic               m_valid_q;
  pixel_t             m_pix_q;

  assign out_free   = !m_valid_q || m_axis_tready;
  assign blend_load = (state_q == ST_BLEND) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_action == ACT_SAMPLE) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_ADDR;
      ST_ADDR: begin
        state_d = ST_READ;
        cnt_d   = '0;
      end
      ST_READ: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // memory port control: writes while idle, neighbor reads while sampling
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [PIX_W-1:0]  ram_rdata;
  pixel_t            rd_pix;
  logic              wr_in_range;
  logic [LW-1:0]     wr_lin, rd_lin;
  logic [XW-1:0]     rd_x;
  logic [YW-1:0]     rd_y;

  assign wr_in_range = (32'(in_col) < 32'(MAX_WIDTH)) && (32'(in_row) < 32'(MAX_HEIGHT));
  assign wr_lin = LW'(in_row) * LW'(MAX_WIDTH) + LW'(in_col);
  // neighbor order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
  assign rd_x   = cnt_q[0] ? x1_q : x0_q;
  assign rd_y   = cnt_q[1] ? y1_q : y0_q;
  assign rd_lin = LW'(rd_y) * LW'(MAX_WIDTH) + LW'(rd_x);
  assign rd_pix = pixel_t'(ram_rdata);

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = rd_lin[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_we        = in_fire && in_action == ACT_WRITE && wr_in_range;
        ram_addr      = wr_lin[AW-1:0];
      end
      default: ;
    endcase
  end

  irs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_pixel_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (PIX_W'(in_pix)),
    .rdata_o (ram_rdata)
  );

  // coordinate mapping and neighbor indexes
  logic [SIZE_W-1:0] ix, iy, x0_full, y0_full, x1_full, y1_full;
  logic [POS_W:0]    sx_rnd, sy_rnd;

  always_comb begin
    sx_rnd = {1'b0, sx_q} + (POS_W+1)'(1 << (FRAC_W - 1));
    sy_rnd = {1'b0, sy_q} + (POS_W+1)'(1 << (FRAC_W - 1));
    if (mode_q == MODE_NEAREST) begin
      ix = SIZE_W'(sx_rnd[POS_W:FRAC_W]);
      iy = SIZE_W'(sy_rnd[POS_W:FRAC_W]);
    end else begin
      ix = SIZE_W'(sx_q[POS_W-1:FRAC_W]);
      iy = SIZE_W'(sy_q[POS_W-1:FRAC_W]);
    end
    x0_full = (ix >= w_eff) ? w_last : ix;
    y0_full = (iy >= h_eff) ? h_last : iy;
    // nearest mode reuses the blend with zero weights and equal neighbors
    if (mode_q == MODE_NEAREST || x0_full == w_last) begin
      x1_full = x0_full;
    end else begin
      x1_full = x0_full + SIZE_W'(1);
    end
    if (mode_q == MODE_NEAREST || y0_full == h_last) begin
      y1_full = y0_full;
    end else begin
      y1_full = y0_full + SIZE_W'(1);
    end
  end

  // datapath registers, one step per state
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_fire) begin
      col_q <= in_col;
      row_q <= in_row;
    end
    if (state_q == ST_MUL) begin
      sx_q <= POS_W'(col_q) * POS_W'(scale_q);
      sy_q <= POS_W'(row_q) * POS_W'(scale_q);
    end
    if (state_q == ST_ADDR) begin
      x0_q <= x0_full[XW-1:0];
      x1_q <= x1_full[XW-1:0];
      y0_q <= y0_full[YW-1:0];
      y1_q <= y1_full[YW-1:0];
      fa_q <= (mode_q == MODE_BILINEAR) ? sx_q[FRAC_W-1:0] : '0;
      fb_q <= (mode_q == MODE_BILINEAR) ? sy_q[FRAC_W-1:0] : '0;
    end
    if (state_q == ST_READ) begin
      // read data arrives in the cycle after its address
      if (cnt_q == 3'd1 || cnt_q == 3'd3) begin
        pix_q <= rd_pix;
      end
      for (int c = 0; c < NCHAN; c++) begin
        if (cnt_q == 3'd2) begin
          t0_q[c] <= hblend(pix_q[c], rd_pix[c], fa_q);
        end
        if (cnt_q == 3'd4) begin
          t1_q[c] <= hblend(pix_q[c], rd_pix[c], fa_q);
        end
      end
    end
    if (blend_load) begin
      for (int c = 0; c < NCHAN; c++) begin
        m_pix_q[c] <= vblend(t0_q[c], t1_q[c], fb_q);
      end
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (blend_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = PIX_W'(m_pix_q);

`ifndef SYNTH
  // a sample word starts the multiply step right away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) |=> (state_q == ST_MUL))
    else $error("sample word did not start the coordinate multiply");

  // right and lower neighbors are the same or the next column / row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |->
      ((x1_q == x0_q || x1_q == x0_q + XW'(1)) && (y1_q == y0_q || y1_q == y0_q + YW'(1))))
    else $error("neighbor indexes out of step");

  // a finished blend shows up on the result port next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    blend_load |=> m_axis_tvalid)
    else $error("blended pixel not presented");

  // no store write while a sample is reading neighbors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !ram_we && !s_axis_tready)
    else $error("store written during neighbor reads");
`endif

endmodule

>>> sv/irs_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module irs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write when enabled, read always; data out in the next cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/image_rescale_sampler_tb.sv
// Self-checking testbench for image_rescale_sampler: loads source pixels, resamples
// them under a range of sizes, scales and modes, and checks every result word.
// Depends on irs_pkg and image_rescale_sampler.
module image_rescale_sampler_tb;
  import irs_pkg::*;

  localparam int MAX_W       = 256;
  localparam int MAX_H       = 256;
  localparam int PW          = POS_W + 1;
  localparam int DRAIN_CYC   = 16;
  localparam int STALL_LIMIT = 2000;

  // One input word: write a source pixel or sample an output pixel
  typedef struct {
    action_e               act;
    logic [COORD_W-1:0]    col;
    logic [COORD_W-1:0]    row;
    pixel_t                color;
  } pix_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index_i = CFG_SRC_WIDTH;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata = '0;  // column, row, red_in, green_in, blue_in, pad
  logic [0:0]            s_axis_tuser = '0;  // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;       // red_out, green_out, blue_out

  image_rescale_sampler #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the block: configuration and source image
  logic [DIM_W-1:0]   width_reg  = 9'd256;
  logic [DIM_W-1:0]   height_reg = 9'd256;
  logic [SCALE_W-1:0] scale_reg  = 18'h10000;
  mode_e              mode_reg   = MODE_BILINEAR;
  pixel_t             img [0:MAX_W*MAX_H-1];

  // Generator bookkeeping: pixels that some queued word already writes
  bit                 planned [0:MAX_W*MAX_H-1];
  pix_word_t          word_q [$];
  pixel_t             pixel_q [$];
  int                 words_queued;
  int                 words_accepted;
  int                 words_made;
  int                 errors;
  bit                 steady;

  pix_word_t          cur;
  int unsigned        send_gap;
  int unsigned        recv_gap;
  int unsigned        idle_cycles;
  pixel_t             got_px;
  pixel_t             want_px;
  string              chan_name [NCHAN] = '{"red_out", "green_out", "blue_out"};

  function automatic int unsigned eff_size(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Map an output coordinate onto the source axis: near tap, far tap, fraction.
  // Nearest mode rounds and carries no fraction, so the far tap gets no weight.
  function automatic void map_axis(input logic [COORD_W-1:0] coord, input int unsigned size,
                                   output int unsigned lo, output int unsigned hi,
                                   output logic [FRAC_W-1:0] frac);
    logic [PW-1:0] pos;
    logic [PW-1:0] idx;
    pos = PW'(coord) * PW'(scale_reg);
    if (mode_reg == MODE_NEAREST) begin
      idx  = (pos + PW'(32'h8000)) >> FRAC_W;
      frac = '0;
    end else begin
      idx  = pos >> FRAC_W;
      frac = pos[FRAC_W-1:0];
    end
    lo = (idx >= size) ? size - 1 : int'(idx);
    hi = (lo + 1 >= size) ? size - 1 : lo + 1;
  endfunction

  // Expected pixel for a sample word under the current shadow state
  function automatic pixel_t resample(input logic [COORD_W-1:0] col,
                                      input logic [COORD_W-1:0] row);
    int unsigned       x0, x1, y0, y1;
    logic [FRAC_W-1:0] a, b;
    logic [FRAC_W:0]   na, nb;
    pixel_t            p00, p10, p01, p11, res;
    logic [63:0]       acc;
    map_axis(col, eff_size(width_reg, MAX_W), x0, x1, a);
    map_axis(row, eff_size(height_reg, MAX_H), y0, y1, b);
    p00 = img[y0*MAX_W + x0];
    p10 = img[y0*MAX_W + x1];
    p01 = img[y1*MAX_W + x0];
    p11 = img[y1*MAX_W + x1];
    na  = 17'h10000 - {1'b0, a};
    nb  = 17'h10000 - {1'b0, b};
    for (int c = 0; c < NCHAN; c++) begin
      acc = 64'(na) * 64'(nb) * 64'(p00[c]) + 64'(a) * 64'(nb) * 64'(p10[c])
          + 64'(na) * 64'(b) * 64'(p01[c]) + 64'(a) * 64'(b) * 64'(p11[c]);
      acc = (acc + 64'h8000_0000) >> 32;
      res[c] = (acc > 64'd255) ? 8'hFF : acc[7:0];
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones; none in steady stretches
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 13);
  endfunction

  // Largest useful output coordinate for the current image and scale
  function automatic int unsigned out_span(input int unsigned size);
    int unsigned s;
    if (scale_reg == 0) return 1023;
    s = (size * 32'd65536) / scale_reg + 1;
    return (s > 1023) ? 1023 : s;
  endfunction

  task automatic push_write(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                            input pixel_t color);
    pix_word_t w;
    w.act   = ACT_WRITE;
    w.col   = col;
    w.row   = row;
    w.color = color;
    if (col < MAX_W && row < MAX_H) begin
      planned[row*MAX_W + col] = 1'b1;
      words_made++;
    end
    word_q.push_back(w);
    words_queued++;
  endtask

  // A sample first loads any tap that nothing has written yet
  task automatic push_sample(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    int unsigned       tx [2];
    int unsigned       ty [2];
    logic [FRAC_W-1:0] a, b;
    pix_word_t         w;
    map_axis(col, eff_size(width_reg, MAX_W), tx[0], tx[1], a);
    map_axis(row, eff_size(height_reg, MAX_H), ty[0], ty[1], b);
    foreach (ty[j])
      foreach (tx[i])
        if (!planned[ty[j]*MAX_W + tx[i]])
          push_write(COORD_W'(tx[i]), COORD_W'(ty[j]), pixel_t'($urandom));
    w.act   = ACT_SAMPLE;
    w.col   = col;
    w.row   = row;
    w.color = '0;
    word_q.push_back(w);
    words_queued++;
    words_made++;
  endtask

  task automatic random_words(input int n);
    int unsigned r, xs, ys, ew, eh;
    int          target;
    target = words_made + n;
    ew = eff_size(width_reg, MAX_W);
    eh = eff_size(height_reg, MAX_H);
    xs = out_span(ew);
    ys = out_span(eh);
    while (words_made < target) begin
      r = $urandom_range(99);
      if (r < 4)
        push_write(COORD_W'($urandom_range(1023, MAX_W)), COORD_W'($urandom),
                   pixel_t'($urandom));
      else if (r < 7)
        push_write(COORD_W'($urandom), COORD_W'($urandom_range(1023, MAX_H)),
                   pixel_t'($urandom));
      else if (r < 28)
        push_write(COORD_W'($urandom_range(ew - 1)), COORD_W'($urandom_range(eh - 1)),
                   pixel_t'($urandom));
      else if (r < 42)
        push_sample(COORD_W'($urandom), COORD_W'($urandom));
      else
        push_sample(COORD_W'($urandom_range(xs)), COORD_W'($urandom_range(ys)));
    end
  endtask

  // One register write; the caller lowers valid after its last write
  task automatic send_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SRC_WIDTH:   width_reg  = val[DIM_W-1:0];
      CFG_SRC_HEIGHT:  height_reg = val[DIM_W-1:0];
      CFG_INV_SCALE:   scale_reg  = val[SCALE_W-1:0];
      CFG_SAMPLE_MODE: mode_reg   = mode_e'(val[0]);
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] wd, input logic [CFG_W-1:0] hd,
                              input logic [CFG_W-1:0] sd, input logic [CFG_W-1:0] md);
    send_reg(CFG_SRC_WIDTH, wd);
    send_reg(CFG_SRC_HEIGHT, hd);
    send_reg(CFG_INV_SCALE, sd);
    send_reg(CFG_SAMPLE_MODE, md);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every word is taken and every pixel returned, then let writes settle
  task automatic wait_drained();
    while (words_accepted != words_queued || pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // Input driver; the shadow model advances as each word is accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        words_accepted++;
        if (cur.act == ACT_WRITE) begin
          if (cur.col < MAX_W && cur.row < MAX_H)
            img[cur.row*MAX_W + cur.col] = cur.color;
        end else begin
          pixel_q.push_back(resample(cur.col, cur.row));
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (word_q.size() != 0) begin
          cur = word_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur.act;
          s_axis_tdata  <= {4'b0, cur.color[2], cur.color[1], cur.color[0], cur.row, cur.col};
          send_gap = draw_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_px = m_axis_tdata;
        if (pixel_q.size() == 0) begin
          $error("result word with no sample pending: %h", m_axis_tdata);
          errors++;
        end else begin
          want_px = pixel_q.pop_front();
          for (int c = 0; c < NCHAN; c++)
            if (got_px[c] !== want_px[c]) begin
              $error("%s expected %0d got %0d", chan_name[c], want_px[c], got_px[c]);
              errors++;
            end
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap = draw_gap();
      end
    end
  end

  // Watchdog: too long without any handshake means the block hung
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned w, h, s;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: full-size image, unit scale, bilinear
    push_write(10'd1023, 10'd1023, '1);
    push_write(10'd256, 10'd0, '1);
    push_write(10'd0, 10'd256, '1);
    push_write(10'd0, 10'd0, '0);
    push_write(10'd1, 10'd0, '1);
    push_write(10'd0, 10'd1, pixel_t'(24'h00FF00));
    push_write(10'd1, 10'd1, pixel_t'(24'hFF00FF));
    push_sample(10'd0, 10'd0);
    push_sample(10'd1, 10'd1);
    push_write(10'd255, 10'd255, '1);
    push_sample(10'd255, 10'd255);
    push_sample(10'd1023, 10'd1023);
    push_sample(10'd1023, 10'd0);
    random_words(25);
    wait_drained();

    // Zero sizes act as one, zero scale pins everything to the origin; nearest
    program_regs('0, '0, '0, CFG_W'(MODE_NEAREST));
    push_sample(10'd0, 10'd0);
    push_sample(10'd1023, 10'd1023);
    push_sample(10'd512, 10'd3);
    random_words(8);
    wait_drained();

    // Oversize image with junk in the upper data bits, largest scale, bilinear
    program_regs('1, {9'h1FF, 9'd300}, 18'h3FFFF, '1);
    push_sample(10'd1, 10'd1);
    push_sample(10'd63, 10'd64);
    random_words(20);
    wait_drained();

    // Smallest image, smallest nonzero scale
    program_regs(18'd1, 18'd1, 18'd1, CFG_W'(MODE_BILINEAR));
    random_words(15);
    wait_drained();

    // Random settings; a few wide, short strips and some runs without idling
    for (int p = 0; p < 12; p++) begin
      w = $urandom_range(20, 1);
      h = $urandom_range(20, 1);
      if (p % 4 == 3) begin
        w = $urandom_range(256, 100);
        h = $urandom_range(3, 1);
      end
      if (p % 4 == 1)
        s = $urandom_range(262143, 0);
      else
        s = $urandom_range(32'h20000, 32'h2000);
      steady = (p % 5 == 2);
      program_regs({9'($urandom), 9'(w)}, {9'($urandom), 9'(h)}, 18'(s),
                   {17'($urandom), 1'($urandom)});
      random_words(50);
      wait_drained();
    end

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
